// ----- rtl/asa_pkg.sv -----
// ----------------------------------------------------------------------------
// asa_pkg
// Shared widths, request codes and default sizes for the address-space
// identifier slot allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package asa_pkg;

   // field widths
   localparam int OP_W   = 2;
   localparam int PID_W  = 16;
   localparam int ASID_W = 9;

   // request codes
   localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
   localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
   localparam logic [OP_W-1:0] OP_PARK    = 2'd2;

   // default table geometry
   localparam int DEF_ASID_SLOTS = 256;
   localparam int DEF_OWNER_BITS = 16;

   // start-slot reduction: reciprocal multiply, then multiply and subtract
   localparam int MOD_STEPS = 2;
   localparam int MOD_CNT_W = $clog2(MOD_STEPS);

endpackage

`default_nettype wire

// ----- rtl/asa_ram.sv -----
// ----------------------------------------------------------------------------
// asa_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module asa_ram #(
   parameter int WIDTH = 18,
   parameter int DEPTH = 256
) (
   input  wire                      clock,
   input  wire                      wr_en,
   input  wire [$clog2(DEPTH)-1:0]  wr_addr,
   input  wire [WIDTH-1:0]          wr_data,
   input  wire [$clog2(DEPTH)-1:0]  rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// ----- rtl/asid_slot_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// asid_slot_allocator_unit
// Address-space identifier table: allocate, release and park slots.
// ----------------------------------------------------------------------------
// Usage:
//  - req_ channel takes one request (operation, process_id, held_asid) at a
//    time; rsp_ channel returns exactly one response per request
//    (new_asid, needs_flush, table_full).
//  - slot state (owner, used, parked) lives in one RAM, one word per slot,
//    with a registered read.
//  - allocate: the start slot is first reduced modulo ASID_SLOTS (reciprocal
//    multiply, then multiply and subtract), then the table is probed one
//    slot per cycle with reads pipelined one ahead; a full sweep with no
//    usable slot sets table_full; then the response register is loaded.
//  - release and park: a read, a check-and-write step, then the response
//    step; unknown codes go straight to the response step.
//  - after reset a clearing pass zeroes the RAM; no request is taken
//    until it finishes.
//  - a new request is accepted while the previous response still waits in
//    the output register; its own response waits until that one is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module asid_slot_allocator_unit #(
   parameter int ASID_SLOTS = asa_pkg::DEF_ASID_SLOTS,
   parameter int OWNER_BITS = asa_pkg::DEF_OWNER_BITS
) (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             req_valid,
   output logic                            req_ready,
   input  wire  [asa_pkg::OP_W-1:0]        req_operation,
   input  wire  [asa_pkg::PID_W-1:0]       req_process_id,
   input  wire  signed [asa_pkg::ASID_W-1:0] req_held_asid,
   output logic                            rsp_valid,
   input  wire                             rsp_ready,
   output logic signed [asa_pkg::ASID_W-1:0] rsp_new_asid,
   output logic                            rsp_needs_flush,
   output logic                            rsp_table_full
);

   localparam int AW = $clog2(ASID_SLOTS);
   localparam int CW = $clog2(ASID_SLOTS + 1);
   localparam int DW = OWNER_BITS + 2;
   // ceil(2^32 / ASID_SLOTS), exact quotient for any 16-bit source
   localparam logic [31:0] RECIP =
      32'(((64'd1 << 32) + 64'(ASID_SLOTS - 1)) / 64'(ASID_SLOTS));

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MOD,
      ST_PROBE,
      ST_LOOK,
      ST_CHECK,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [OWNER_BITS-1:0] owner;
      logic                  used;
      logic                  parked;
   } slot_type;

   // control registers
   state_type                       state_ff, state_in;
   logic [AW-1:0]                   clr_ff, clr_in;
   logic [asa_pkg::MOD_CNT_W-1:0]   mcnt_ff, mcnt_in;
   logic [CW-1:0]                   pcnt_ff, pcnt_in;
   logic                            chk_vld_ff, chk_vld_in;
   logic                            rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic [asa_pkg::OP_W-1:0]        op_ff, op_in;
   logic [OWNER_BITS-1:0]           pid_ff, pid_in;
   logic signed [asa_pkg::ASID_W-1:0] held_ff, held_in;
   logic [asa_pkg::PID_W-1:0]       src_ff, src_in;
   logic [asa_pkg::PID_W-1:0]       quo_ff, quo_in;
   logic [AW-1:0]                   ptr_ff, ptr_in;
   logic [AW-1:0]                   chk_addr_ff, chk_addr_in;
   logic signed [asa_pkg::ASID_W-1:0] res_asid_ff, res_asid_in;
   logic                            res_flush_ff, res_flush_in;
   logic                            res_full_ff, res_full_in;
   logic signed [asa_pkg::ASID_W-1:0] rsp_asid_ff, rsp_asid_in;
   logic                            rsp_flush_ff, rsp_flush_in;
   logic                            rsp_full_ff, rsp_full_in;

   // RAM ports
   logic                            ram_we;
   logic [AW-1:0]                   ram_waddr;
   slot_type                        ram_wdata;
   logic [AW-1:0]                   ram_raddr;
   logic [DW-1:0]                   ram_rdata;
   slot_type                        slot_rd;

   // helpers
   logic [asa_pkg::ASID_W-1:0]      held_mag;
   logic                            mag_in_range;
   logic [AW-1:0]                   mag_addr;
   logic [asa_pkg::PID_W+31:0]      quo_prod;
   logic [31:0]                     rem_full;
   logic [AW-1:0]                   rem_val;
   logic [AW-1:0]                   ptr_inc;
   logic                            slot_mine;
   logic                            slot_usable;
   logic                            rsp_free;

   asa_ram #(
      .WIDTH (DW),
      .DEPTH (ASID_SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign slot_rd = slot_type'(ram_rdata);

   // magnitude of the held identifier and its range check
   assign held_mag     = held_ff[asa_pkg::ASID_W-1] ? asa_pkg::ASID_W'(-held_ff)
                                                    : asa_pkg::ASID_W'(held_ff);
   assign mag_in_range = (held_mag != '0) && (32'(held_mag) < 32'(ASID_SLOTS));
   assign mag_addr     = AW'(held_mag);

   // start-slot remainder: quotient by reciprocal, then source minus product
   assign quo_prod = (asa_pkg::PID_W+32)'(src_ff) * (asa_pkg::PID_W+32)'(RECIP);
   assign rem_full = 32'(src_ff) - 32'(quo_ff) * 32'(ASID_SLOTS);
   assign rem_val  = AW'(rem_full);

   // probe pointer wraps at the table size
   assign ptr_inc = (ptr_ff == AW'(ASID_SLOTS - 1)) ? '0 : ptr_ff + AW'(1);

   // slot tests on the word just read
   assign slot_mine   = slot_rd.used && (slot_rd.owner == pid_ff);
   assign slot_usable = (chk_addr_ff != '0) &&
                        (!slot_rd.used || (slot_rd.owner == pid_ff) || slot_rd.parked);

   assign rsp_free = !rsp_valid_ff || rsp_ready;

   // read address: probe pointer while sweeping, else the held slot
   assign ram_raddr = (state_ff == ST_PROBE) ? ptr_ff : mag_addr;

   // next-state and datapath
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      mcnt_in      = mcnt_ff;
      pcnt_in      = pcnt_ff;
      chk_vld_in   = chk_vld_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      op_in        = op_ff;
      pid_in       = pid_ff;
      held_in      = held_ff;
      src_in       = src_ff;
      quo_in       = quo_ff;
      ptr_in       = ptr_ff;
      chk_addr_in  = chk_addr_ff;
      res_asid_in  = res_asid_ff;
      res_flush_in = res_flush_ff;
      res_full_in  = res_full_ff;
      rsp_asid_in  = rsp_asid_ff;
      rsp_flush_in = rsp_flush_ff;
      rsp_full_in  = rsp_full_ff;
      ram_we       = 1'b0;
      ram_waddr    = clr_ff;
      ram_wdata    = '0;
      req_ready    = 1'b0;

      case (state_ff)
         // zero every slot after reset
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            clr_in    = clr_ff + AW'(1);
            if (clr_ff == AW'(ASID_SLOTS - 1)) begin
               state_in = ST_IDLE;
            end
         end

         // take a request
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in        = req_operation;
               pid_in       = OWNER_BITS'(req_process_id);
               held_in      = req_held_asid;
               res_asid_in  = req_held_asid;
               res_flush_in = 1'b0;
               res_full_in  = 1'b0;
               src_in       = (req_held_asid != '0)
                              ? asa_pkg::PID_W'($unsigned(req_held_asid[asa_pkg::ASID_W-1]
                                                ? asa_pkg::ASID_W'(-req_held_asid)
                                                : asa_pkg::ASID_W'(req_held_asid)))
                              : req_process_id;
               ptr_in       = '0;
               mcnt_in      = '0;
               case (req_operation)
                  asa_pkg::OP_ALLOC: begin
                     state_in = ST_MOD;
                  end
                  asa_pkg::OP_RELEASE: begin
                     res_asid_in = '0;
                     state_in    = ST_LOOK;
                  end
                  asa_pkg::OP_PARK: begin
                     if (!req_held_asid[asa_pkg::ASID_W-1] && req_held_asid != '0) begin
                        res_asid_in = -req_held_asid;
                     end
                     state_in = ST_LOOK;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end

         // start slot = source modulo table size: quotient, then remainder
         ST_MOD: begin
            mcnt_in = mcnt_ff + asa_pkg::MOD_CNT_W'(1);
            if (mcnt_ff == '0) begin
               quo_in = quo_prod[asa_pkg::PID_W+31:32];
            end
            if (mcnt_ff == asa_pkg::MOD_CNT_W'(asa_pkg::MOD_STEPS - 1)) begin
               ptr_in     = rem_val;
               chk_vld_in = 1'b0;
               pcnt_in    = '0;
               state_in   = ST_PROBE;
            end
         end

         // sweep: issue read at pointer, check word of the previous slot
         ST_PROBE: begin
            ptr_in      = ptr_inc;
            chk_addr_in = ptr_ff;
            chk_vld_in  = 1'b1;
            if (chk_vld_ff) begin
               if (slot_usable) begin
                  ram_we          = 1'b1;
                  ram_waddr       = chk_addr_ff;
                  ram_wdata.owner = pid_ff;
                  ram_wdata.used  = 1'b1;
                  res_flush_in    = !slot_mine;
                  res_asid_in     = asa_pkg::ASID_W'(chk_addr_ff);
                  state_in        = ST_DONE;
               end else begin
                  pcnt_in = pcnt_ff + CW'(1);
                  if (pcnt_ff + CW'(1) == CW'(ASID_SLOTS)) begin
                     res_full_in = 1'b1;
                     state_in    = ST_DONE;
                  end
               end
            end
         end

         // read of the held slot is in flight
         ST_LOOK: begin
            state_in = mag_in_range ? ST_CHECK : ST_DONE;
         end

         // release or park a slot the caller owns
         ST_CHECK: begin
            if (slot_mine) begin
               ram_we    = 1'b1;
               ram_waddr = mag_addr;
               if (op_ff == asa_pkg::OP_PARK) begin
                  ram_wdata        = slot_rd;
                  ram_wdata.parked = 1'b1;
               end
            end
            state_in = ST_DONE;
         end

         // hand the result to the response register when it is free
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_asid_in  = res_asid_ff;
               rsp_flush_in = res_flush_ff;
               rsp_full_in  = res_full_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      pid_ff       <= pid_in;
      held_ff      <= held_in;
      src_ff       <= src_in;
      quo_ff       <= quo_in;
      ptr_ff       <= ptr_in;
      chk_addr_ff  <= chk_addr_in;
      res_asid_ff  <= res_asid_in;
      res_flush_ff <= res_flush_in;
      res_full_ff  <= res_full_in;
      rsp_asid_ff  <= rsp_asid_in;
      rsp_flush_ff <= rsp_flush_in;
      rsp_full_ff  <= rsp_full_in;
      mcnt_ff      <= mcnt_in;
      pcnt_ff      <= pcnt_in;
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         chk_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         chk_vld_ff   <= chk_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_new_asid    = rsp_asid_ff;
   assign rsp_needs_flush = rsp_flush_ff;
   assign rsp_table_full  = rsp_full_ff;

`ifndef NO_ASSERTIONS
   // the reserved slot is only ever written by the clearing pass
   a_no_slot0_write: assert property (@(posedge clock) disable iff (reset)
      (ram_we && state_ff != ST_CLEAR) |-> (ram_waddr != '0))
      else $error("reserved slot written outside clearing pass");

   // a response appears only out of the done state
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff)) |-> ($past(state_ff) == ST_DONE))
      else $error("response raised outside done state");

   // a full table never asks for a flush
   a_full_no_flush: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_full_ff && rsp_flush_ff))
      else $error("table full and flush both set");

   // no request is taken while the table is being cleared
   a_no_req_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !req_ready)
      else $error("request taken during clearing pass");
`endif

endmodule

`default_nettype wire
